FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL module of the transport clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ptc_pkg.sv
// Package with the widths, codes and types of the playback transport clock.
package ptc_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int INT_BITS   = 16;
  localparam int POS_W      = INT_BITS + FRAC_BITS;
  localparam int TGT_W      = POS_W + 1;
  localparam int STEP_W     = 32;
  localparam int RATE_W     = 24;
  localparam int RATE_FRAC  = 16;
  localparam int SRATE_W    = 19;
  localparam int SMP_W      = 35;
  localparam int MODE_W     = 2;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  localparam int MUL_A_W    = POS_W;
  localparam int MUL_B_W    = RATE_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = $clog2(MUL_B_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_B_W - 1);

  localparam int REM_N_W    = POS_W + 1;
  localparam int REM_CNT_W  = $clog2(REM_N_W);
  localparam logic [REM_CNT_W-1:0] REM_LAST = REM_CNT_W'(REM_N_W - 1);

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(65536);
  localparam logic [SRATE_W-1:0] SRATE_RESET = SRATE_W'(48000);
  localparam logic [POS_W-1:0]   POS_MAX     = '1;
  localparam logic [MUL_P_W-1:0] SMP_PRELOAD = MUL_P_W'(1) << (FRAC_BITS - 1 + MUL_B_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_SEEK   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE      = 3'd0,
    CFG_LOOP_EN   = 3'd1,
    CFG_LOOP_BEG  = 3'd2,
    CFG_LOOP_END  = 3'd3,
    CFG_DURATION  = 3'd4,
    CFG_SRATE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mcand;
    logic [MUL_B_W-1:0] mplier;
    logic [MUL_P_W-1:0] preload;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [REM_N_W-1:0] dividend;
    logic [POS_W-1:0]   divisor;
  } rem_req_t;

endpackage

FILE: rtl/core/ptc_if.sv
// Channel interfaces of the playback transport clock: input, result and configuration.
interface ptc_in_if;
  logic                              valid;
  logic                              ready;
  logic [ptc_pkg::OP_W-1:0]          operation;
  logic [ptc_pkg::STEP_W-1:0]        step_length;
  logic signed [ptc_pkg::TGT_W-1:0]  target_position;

  modport source (output valid, operation, step_length, target_position, input ready);
  modport sink (input valid, operation, step_length, target_position, output ready);
endinterface

interface ptc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptc_pkg::MODE_W-1:0]   mode_now;
  logic [ptc_pkg::POS_W-1:0]    position_now;
  logic [ptc_pkg::SMP_W-1:0]    sample_position;
  logic                         end_reached;

  modport source (output valid, mode_now, position_now, sample_position, end_reached,
                  input ready);
  modport sink (input valid, mode_now, position_now, sample_position, end_reached,
                output ready);
endinterface

interface ptc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]    index;
  logic [ptc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ptc_mul.sv
// Serial shift-add multiplier, one multiplier bit per cycle, with a preloaded accumulator.
module ptc_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptc_pkg::mul_req_t             req,
  output logic [ptc_pkg::MUL_P_W-1:0]   product,
  output logic                          done
);

  logic [ptc_pkg::MUL_P_W-1:0]   acc_r;
  logic [ptc_pkg::MUL_P_W-1:0]   acc_nxt;
  logic [ptc_pkg::MUL_A_W-1:0]   mcand_r;
  logic [ptc_pkg::MUL_B_W-1:0]   mplier_r;
  logic [ptc_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ptc_pkg::MUL_A_W:0]     partial;

  always_comb begin
    partial = {1'b0, acc_r[ptc_pkg::MUL_P_W-1:ptc_pkg::MUL_B_W]}
            + (mplier_r[0] ? {1'b0, mcand_r} : '0);
    acc_nxt = {partial, acc_r[ptc_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ptc_pkg::MUL_LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ptc_pkg::MUL_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= req.preload;
      mcand_r  <= req.mcand;
      mplier_r <= req.mplier;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mplier_r <= {1'b0, mplier_r[ptc_pkg::MUL_B_W-1:1]};
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

FILE: rtl/core/ptc_rem.sv
// Restoring remainder unit that takes one dividend bit per cycle.
module ptc_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptc_pkg::rem_req_t           req,
  output logic [ptc_pkg::POS_W-1:0]   remainder,
  output logic                        done
);

  logic [ptc_pkg::REM_N_W-1:0]   dvd_r;
  logic [ptc_pkg::POS_W-1:0]     div_r;
  logic [ptc_pkg::POS_W-1:0]     rem_r;
  logic [ptc_pkg::POS_W-1:0]     rem_nxt;
  logic [ptc_pkg::REM_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ptc_pkg::POS_W:0]       trial;
  logic [ptc_pkg::POS_W:0]       diff;

  always_comb begin
    trial = {rem_r, dvd_r[ptc_pkg::REM_N_W-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[ptc_pkg::POS_W-1:0];
    end else begin
      rem_nxt = trial[ptc_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ptc_pkg::REM_LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ptc_pkg::REM_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ptc_pkg::REM_N_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign remainder = rem_r;
  assign done      = done_r;

endmodule

FILE: rtl/core/playback_transport_clock_top.sv
// Top level of the playback transport clock: transport state, configuration and sequencing.
// One item is handled at a time and gives one result. A start, stop, pause, resume, seek,
// unused code or ignored tick goes from the input transfer to the sample conversion and then
// to the result register; a tick while playing first scales its step by the playback rate,
// and folds the position back into the loop region when it wraps. The serial multiplier,
// with a 24-bit multiplier, scales the step and converts the position to samples; the serial
// remainder unit, with a 41-bit dividend, folds the position back into the loop. The next input
// is taken in the cycle after the result register is loaded, while that result still waits.
`include "assert_macros.svh"

module playback_transport_clock_top (
  input  logic            clk,
  input  logic            rst_n,
  ptc_in_if.sink          in_item,
  ptc_out_if.source       out_item,
  ptc_cfg_if.sink         cfg_wr
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_EVAL   = 7'b0000100,
    ST_REM    = 7'b0001000,
    ST_SMP_GO = 7'b0010000,
    ST_SMP    = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  ptc_pkg::mode_t                  mode_r;
  ptc_pkg::mode_t                  mode_nxt;
  logic [ptc_pkg::POS_W-1:0]       pos_r;
  logic [ptc_pkg::POS_W-1:0]       pos_nxt;
  logic [ptc_pkg::POS_W:0]         sum_r;
  logic [ptc_pkg::POS_W:0]         sum_nxt;
  logic [ptc_pkg::POS_W-1:0]       eff_r;
  logic [ptc_pkg::POS_W-1:0]       eff_nxt;
  logic                            ended_r;
  logic                            ended_nxt;
  logic [ptc_pkg::SMP_W-1:0]       samp_r;
  logic [ptc_pkg::SMP_W-1:0]       samp_nxt;

  logic [ptc_pkg::RATE_W-1:0]      rate_r;
  logic                            loop_en_r;
  logic [ptc_pkg::POS_W-1:0]       lbeg_r;
  logic [ptc_pkg::POS_W-1:0]       lend_r;
  logic [ptc_pkg::POS_W-1:0]       dur_r;
  logic [ptc_pkg::SRATE_W-1:0]     srate_r;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [ptc_pkg::MODE_W-1:0]      out_mode_r;
  logic [ptc_pkg::POS_W-1:0]       out_pos_r;
  logic [ptc_pkg::SMP_W-1:0]       out_samp_r;
  logic                            out_end_r;
  logic                            out_load;

  logic                            in_xfer;
  logic                            tick_go;
  logic                            wrap_go;
  ptc_pkg::op_t                    op;
  logic [ptc_pkg::POS_W-1:0]       tgt_pos;
  logic [ptc_pkg::POS_W-1:0]       clamp_pos;
  logic [ptc_pkg::POS_W-1:0]       sum_sat;

  ptc_pkg::mul_req_t               mul_req;
  logic [ptc_pkg::MUL_P_W-1:0]     mul_prod;
  logic                            mul_done;
  ptc_pkg::rem_req_t               rem_req;
  logic [ptc_pkg::POS_W-1:0]       rem_out;
  logic                            rem_done;

  ptc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .product (mul_prod),
    .done    (mul_done)
  );

  ptc_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (rem_req),
    .remainder (rem_out),
    .done      (rem_done)
  );

  assign in_item.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_item.valid && in_item.ready;
  assign op            = ptc_pkg::op_t'(in_item.operation);

  assign tgt_pos = in_item.target_position[ptc_pkg::POS_W-1:0];

  always_comb begin
    if (in_item.target_position[ptc_pkg::TGT_W-1]) begin
      clamp_pos = '0;
    end else if ((dur_r != '0) && (tgt_pos > dur_r)) begin
      clamp_pos = dur_r;
    end else begin
      clamp_pos = tgt_pos;
    end
  end

  assign sum_sat = sum_r[ptc_pkg::POS_W] ? ptc_pkg::POS_MAX : sum_r[ptc_pkg::POS_W-1:0];

  assign tick_go = in_xfer && (op == ptc_pkg::OP_TICK) && (mode_r == ptc_pkg::MODE_PLAYING)
                && (in_item.step_length != '0);
  assign wrap_go = loop_en_r && (eff_r > lbeg_r) && (sum_r >= {1'b0, eff_r});

  always_comb begin
    mul_req.start = tick_go || (state_r == ST_SMP_GO);
    if (state_r == ST_SMP_GO) begin
      mul_req.mcand   = pos_r;
      mul_req.mplier  = ptc_pkg::MUL_B_W'(srate_r);
      mul_req.preload = ptc_pkg::SMP_PRELOAD;
    end else begin
      mul_req.mcand   = ptc_pkg::MUL_A_W'(in_item.step_length);
      mul_req.mplier  = rate_r;
      mul_req.preload = '0;
    end
  end

  always_comb begin
    rem_req.start    = (state_r == ST_EVAL) && wrap_go;
    rem_req.dividend = sum_r - {1'b0, lbeg_r};
    rem_req.divisor  = eff_r - lbeg_r;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    eff_nxt   = eff_r;
    ended_nxt = ended_r;
    samp_nxt  = samp_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ended_nxt = 1'b0;
          state_nxt = ST_SMP_GO;
          case (op)
            ptc_pkg::OP_TICK: begin
              if (tick_go) begin
                eff_nxt   = (lend_r > lbeg_r) ? lend_r : dur_r;
                state_nxt = ST_MUL;
              end
            end
            ptc_pkg::OP_START: begin
              pos_nxt  = clamp_pos;
              mode_nxt = ptc_pkg::MODE_PLAYING;
            end
            ptc_pkg::OP_STOP: begin
              pos_nxt  = '0;
              mode_nxt = ptc_pkg::MODE_STOPPED;
            end
            ptc_pkg::OP_PAUSE: begin
              if (mode_r == ptc_pkg::MODE_PLAYING) begin
                mode_nxt = ptc_pkg::MODE_PAUSED;
              end
            end
            ptc_pkg::OP_RESUME: begin
              if (mode_r == ptc_pkg::MODE_PAUSED) begin
                mode_nxt = ptc_pkg::MODE_PLAYING;
              end
            end
            ptc_pkg::OP_SEEK: begin
              pos_nxt = clamp_pos;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          sum_nxt = {1'b0, pos_r}
                  + {1'b0, mul_prod[ptc_pkg::RATE_FRAC+ptc_pkg::POS_W-1:ptc_pkg::RATE_FRAC]};
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_SMP_GO;
        if (loop_en_r) begin
          if (wrap_go) begin
            state_nxt = ST_REM;
          end else begin
            pos_nxt = sum_sat;
          end
        end else if ((dur_r != '0) && (sum_r >= {1'b0, dur_r})) begin
          pos_nxt   = dur_r;
          mode_nxt  = ptc_pkg::MODE_STOPPED;
          ended_nxt = 1'b1;
        end else begin
          pos_nxt = sum_sat;
        end
      end
      ST_REM: begin
        if (rem_done) begin
          pos_nxt   = lbeg_r + rem_out;
          state_nxt = ST_SMP_GO;
        end
      end
      ST_SMP_GO: begin
        state_nxt = ST_SMP;
      end
      ST_SMP: begin
        if (mul_done) begin
          samp_nxt  = mul_prod[ptc_pkg::FRAC_BITS+ptc_pkg::SMP_W-1:ptc_pkg::FRAC_BITS];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= ptc_pkg::MODE_STOPPED;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    eff_r   <= eff_nxt;
    ended_r <= ended_nxt;
    samp_r  <= samp_nxt;
    if (out_load) begin
      out_mode_r <= mode_r;
      out_pos_r  <= pos_r;
      out_samp_r <= samp_r;
      out_end_r  <= ended_r;
    end
  end

  // A zero playback rate is not taken; the previous rate stays in force.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= ptc_pkg::RATE_RESET;
      loop_en_r <= 1'b0;
      lbeg_r    <= '0;
      lend_r    <= '0;
      dur_r     <= '0;
      srate_r   <= ptc_pkg::SRATE_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (ptc_pkg::cfg_idx_t'(cfg_wr.index))
        ptc_pkg::CFG_RATE: begin
          if (cfg_wr.data[ptc_pkg::RATE_W-1:0] != '0) begin
            rate_r <= cfg_wr.data[ptc_pkg::RATE_W-1:0];
          end
        end
        ptc_pkg::CFG_LOOP_EN: begin
          loop_en_r <= cfg_wr.data[0];
        end
        ptc_pkg::CFG_LOOP_BEG: begin
          lbeg_r <= cfg_wr.data[ptc_pkg::POS_W-1:0];
        end
        ptc_pkg::CFG_LOOP_END: begin
          lend_r <= cfg_wr.data[ptc_pkg::POS_W-1:0];
        end
        ptc_pkg::CFG_DURATION: begin
          dur_r <= cfg_wr.data[ptc_pkg::POS_W-1:0];
        end
        ptc_pkg::CFG_SRATE: begin
          srate_r <= cfg_wr.data[ptc_pkg::SRATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  assign out_item.valid           = out_valid_r;
  assign out_item.mode_now        = out_mode_r;
  assign out_item.position_now    = out_pos_r;
  assign out_item.sample_position = out_samp_r;
  assign out_item.end_reached     = out_end_r;

  `PTC_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_item.ready, "input taken while busy")
  `PTC_ASSERT_IMPL(a_mul_done_state, mul_done, (state_r == ST_MUL) || (state_r == ST_SMP), "multiplier done in wrong state")
  `PTC_ASSERT_IMPL(a_rem_done_state, rem_done, state_r == ST_REM, "remainder done in wrong state")
  `PTC_ASSERT_IMPL(a_end_stops, out_valid_r && out_end_r, out_mode_r == ptc_pkg::MODE_STOPPED, "end flag without stop")

endmodule

FILE: bench/tb.sv
// Self-checking bench for the playback transport clock: directed and random operations.
`timescale 1ns / 1ps

module tb;

  localparam logic [ptc_pkg::OP_W-1:0]  OP_SPARE_A  = 3'd6;
  localparam logic [ptc_pkg::OP_W-1:0]  OP_SPARE_B  = 3'd7;
  localparam logic [ptc_pkg::POS_W-1:0] ONE_SEC     = ptc_pkg::POS_W'(1) << ptc_pkg::FRAC_BITS;
  localparam logic [63:0]               SMP_SAT     = (64'd1 << ptc_pkg::SMP_W) - 64'd1;
  localparam int                        STALL_LIMIT = 3000;
  localparam int                        PHASE_ITEMS = 120;

  typedef struct packed {
    logic [ptc_pkg::OP_W-1:0]   op;
    logic [ptc_pkg::STEP_W-1:0] step;
    logic [ptc_pkg::TGT_W-1:0]  target;
  } xport_cmd_t;

  typedef struct packed {
    ptc_pkg::mode_t            mode;
    logic [ptc_pkg::POS_W-1:0] pos;
    logic [ptc_pkg::SMP_W-1:0] samples;
    logic                      ended;
  } xport_res_t;

  logic clk;
  logic rst_n;

  ptc_in_if  in_bus();
  ptc_out_if out_bus();
  ptc_cfg_if cfg_bus();

  playback_transport_clock_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus.sink),
    .out_item (out_bus.source),
    .cfg_wr   (cfg_bus.sink)
  );

  xport_cmd_t pending[$];
  xport_res_t results_due[$];
  xport_cmd_t on_bus;
  xport_res_t want;
  int         send_gap    = 0;
  int         take_stall  = 0;
  int         errors      = 0;
  int         idle_cycles = 0;
  bit         quiet       = 1'b0;

  logic [ptc_pkg::RATE_W-1:0]  rate_q     = ptc_pkg::RATE_RESET;
  logic                        loop_on    = 1'b0;
  logic [ptc_pkg::POS_W-1:0]   loop_lo    = '0;
  logic [ptc_pkg::POS_W-1:0]   loop_hi    = '0;
  logic [ptc_pkg::POS_W-1:0]   media_len  = '0;
  logic [ptc_pkg::SRATE_W-1:0] srate      = ptc_pkg::SRATE_RESET;
  ptc_pkg::mode_t              xport_mode = ptc_pkg::MODE_STOPPED;
  logic [ptc_pkg::POS_W-1:0]   xport_pos  = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [ptc_pkg::POS_W-1:0] clamp_goal(logic [ptc_pkg::TGT_W-1:0] t);
    logic [ptc_pkg::POS_W-1:0] v;
    if (t[ptc_pkg::TGT_W-1]) return '0;
    v = t[ptc_pkg::POS_W-1:0];
    if (media_len != '0 && v > media_len) v = media_len;
    return v;
  endfunction

  function automatic xport_res_t advance_transport(xport_cmd_t c);
    xport_res_t res;
    logic [63:0] sum;
    logic [63:0] span_end;
    logic [63:0] smp;
    logic        ended;
    ended = 1'b0;
    case (c.op)
      ptc_pkg::OP_TICK: begin
        if (xport_mode == ptc_pkg::MODE_PLAYING && c.step != '0) begin
          sum = 64'(xport_pos) + ((64'(c.step) * 64'(rate_q)) >> ptc_pkg::RATE_FRAC);
          if (loop_on) begin
            span_end = (loop_hi > loop_lo) ? 64'(loop_hi) : 64'(media_len);
            if (span_end > 64'(loop_lo) && sum >= span_end)
              sum = 64'(loop_lo) + (sum - 64'(loop_lo)) % (span_end - 64'(loop_lo));
          end else if (media_len != '0 && sum >= 64'(media_len)) begin
            sum = 64'(media_len);
            xport_mode = ptc_pkg::MODE_STOPPED;
            ended = 1'b1;
          end
          xport_pos = (sum > 64'(ptc_pkg::POS_MAX)) ? ptc_pkg::POS_MAX
                                                     : sum[ptc_pkg::POS_W-1:0];
        end
      end
      ptc_pkg::OP_START: begin
        xport_pos = clamp_goal(c.target);
        xport_mode = ptc_pkg::MODE_PLAYING;
      end
      ptc_pkg::OP_STOP: begin
        xport_mode = ptc_pkg::MODE_STOPPED;
        xport_pos = '0;
      end
      ptc_pkg::OP_PAUSE:
        if (xport_mode == ptc_pkg::MODE_PLAYING) xport_mode = ptc_pkg::MODE_PAUSED;
      ptc_pkg::OP_RESUME:
        if (xport_mode == ptc_pkg::MODE_PAUSED) xport_mode = ptc_pkg::MODE_PLAYING;
      ptc_pkg::OP_SEEK: xport_pos = clamp_goal(c.target);
      default: ;
    endcase
    if (srate == '0) begin
      smp = '0;
    end else begin
      smp = 64'(xport_pos[ptc_pkg::POS_W-1:ptc_pkg::FRAC_BITS]) * 64'(srate)
          + ((64'(xport_pos[ptc_pkg::FRAC_BITS-1:0]) * 64'(srate)
              + (64'd1 << (ptc_pkg::FRAC_BITS - 1))) >> ptc_pkg::FRAC_BITS);
    end
    res.mode    = xport_mode;
    res.pos     = xport_pos;
    res.samples = (smp > SMP_SAT) ? SMP_SAT[ptc_pkg::SMP_W-1:0] : smp[ptc_pkg::SMP_W-1:0];
    res.ended   = ended;
    return res;
  endfunction

  function automatic xport_cmd_t make_cmd();
    xport_cmd_t  c;
    logic [63:0] wide;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 55) c.op = ptc_pkg::OP_TICK;
    else if (r < 65) c.op = ptc_pkg::OP_START;
    else if (r < 75) c.op = ptc_pkg::OP_SEEK;
    else if (r < 82) c.op = ptc_pkg::OP_PAUSE;
    else if (r < 89) c.op = ptc_pkg::OP_RESUME;
    else if (r < 95) c.op = ptc_pkg::OP_STOP;
    else if (r < 97) c.op = OP_SPARE_A;
    else c.op = OP_SPARE_B;
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 19))
      0: c.step = '0;
      1: c.step = '1;
      2, 3: c.step = wide[ptc_pkg::STEP_W-1:0];
      4, 5, 6: c.step = $urandom_range(1, 1 << 16);
      default: c.step = $urandom_range(1, 1 << 24) >> $urandom_range(0, 4);
    endcase
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: c.target = {1'b1, wide[ptc_pkg::POS_W-1:0]};
      1: c.target = wide[ptc_pkg::TGT_W-1:0];
      2: begin
        case ($urandom_range(0, 3))
          0: c.target = '0;
          1: c.target = {1'b0, {ptc_pkg::POS_W{1'b1}}};
          2: c.target = {1'b1, {ptc_pkg::POS_W{1'b0}}};
          default: c.target = '1;
        endcase
      end
      default: begin
        if (media_len != '0)
          c.target = ptc_pkg::TGT_W'(wide % (64'(media_len) + 64'(media_len >> 2)
                                             + 64'd1));
        else
          c.target = ptc_pkg::TGT_W'(wide[ptc_pkg::POS_W-1:0] >> $urandom_range(0, 24));
      end
    endcase
    return c;
  endfunction

  task automatic queue_cmd(input logic [ptc_pkg::OP_W-1:0] op,
                           input logic [ptc_pkg::STEP_W-1:0] step,
                           input logic [ptc_pkg::TGT_W-1:0] target);
    xport_cmd_t c;
    c.op = op;
    c.step = step;
    c.target = target;
    pending.push_back(c);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || in_bus.valid || results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ptc_pkg::cfg_idx_t idx,
                           input logic [ptc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      ptc_pkg::CFG_RATE:
        if (value[ptc_pkg::RATE_W-1:0] != '0) rate_q = value[ptc_pkg::RATE_W-1:0];
      ptc_pkg::CFG_LOOP_EN: loop_on = value[0];
      ptc_pkg::CFG_LOOP_BEG: loop_lo = value;
      ptc_pkg::CFG_LOOP_END: loop_hi = value;
      ptc_pkg::CFG_DURATION: media_len = value;
      ptc_pkg::CFG_SRATE: srate = value[ptc_pkg::SRATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [ptc_pkg::CFG_DATA_W-1:0] rate,
                       input logic [ptc_pkg::CFG_DATA_W-1:0] loop,
                       input logic [ptc_pkg::CFG_DATA_W-1:0] lo,
                       input logic [ptc_pkg::CFG_DATA_W-1:0] hi,
                       input logic [ptc_pkg::CFG_DATA_W-1:0] len,
                       input logic [ptc_pkg::CFG_DATA_W-1:0] sr);
    write_reg(ptc_pkg::CFG_RATE, rate);
    write_reg(ptc_pkg::CFG_LOOP_EN, loop);
    write_reg(ptc_pkg::CFG_LOOP_BEG, lo);
    write_reg(ptc_pkg::CFG_LOOP_END, hi);
    write_reg(ptc_pkg::CFG_DURATION, len);
    write_reg(ptc_pkg::CFG_SRATE, sr);
  endtask

  task automatic run_random(input int count);
    repeat (count) pending.push_back(make_cmd());
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        results_due.push_back(advance_transport(on_bus));
        send_gap = pick_idle();
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap == 0 && pending.size() != 0) begin
          on_bus = pending.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.operation       <= on_bus.op;
          in_bus.step_length     <= on_bus.step;
          in_bus.target_position <= on_bus.target;
        end else begin
          in_bus.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected: position_now %0h",
                 out_bus.position_now);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_bus.mode_now !== want.mode) begin
            $error("mode_now expected %0d actual %0d", want.mode, out_bus.mode_now);
            errors++;
          end
          if (out_bus.position_now !== want.pos) begin
            $error("position_now expected %0h actual %0h", want.pos, out_bus.position_now);
            errors++;
          end
          if (out_bus.sample_position !== want.samples) begin
            $error("sample_position expected %0d actual %0d", want.samples,
                   out_bus.sample_position);
            errors++;
          end
          if (out_bus.end_reached !== want.ended) begin
            $error("end_reached expected %0d actual %0d", want.ended, out_bus.end_reached);
            errors++;
          end
        end
      end
      if (take_stall > 0) begin
        out_bus.ready <= 1'b0;
        take_stall--;
      end else begin
        out_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) take_stall = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    in_bus.valid           = 1'b0;
    in_bus.operation       = '0;
    in_bus.step_length     = '0;
    in_bus.target_position = '0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = ptc_pkg::CFG_RATE;
    cfg_bus.data           = '0;
    rst_n                  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unit rate, no duration, no loop.
    queue_cmd(ptc_pkg::OP_TICK, 32'h0100_0000, '0);
    queue_cmd(ptc_pkg::OP_PAUSE, '0, '0);
    queue_cmd(ptc_pkg::OP_RESUME, '0, '0);
    queue_cmd(ptc_pkg::OP_START, '0, '1);
    queue_cmd(ptc_pkg::OP_TICK, '0, '0);
    queue_cmd(ptc_pkg::OP_TICK, 32'h0100_0000, '0);
    queue_cmd(ptc_pkg::OP_TICK, 32'd1, '0);
    queue_cmd(ptc_pkg::OP_PAUSE, '0, '0);
    queue_cmd(ptc_pkg::OP_PAUSE, '0, '0);
    queue_cmd(ptc_pkg::OP_TICK, 32'h0080_0000, '0);
    queue_cmd(ptc_pkg::OP_RESUME, '0, '0);
    queue_cmd(ptc_pkg::OP_RESUME, '0, '0);
    queue_cmd(ptc_pkg::OP_SEEK, '0, {1'b1, {ptc_pkg::POS_W{1'b0}}});
    queue_cmd(ptc_pkg::OP_SEEK, '0, {1'b0, {ptc_pkg::POS_W{1'b1}}});
    queue_cmd(ptc_pkg::OP_TICK, '1, '0);
    queue_cmd(OP_SPARE_A, '1, '1);
    queue_cmd(OP_SPARE_B, '0, '0);
    queue_cmd(ptc_pkg::OP_STOP, '1, '1);
    queue_cmd(ptc_pkg::OP_SEEK, '0, ptc_pkg::TGT_W'(ONE_SEC * 5 / 2));
    drain();

    // A short media length: targets are capped and ticks run into the end.
    setup(ptc_pkg::CFG_DATA_W'(ptc_pkg::RATE_RESET), 0, 0, 0, 3 * ONE_SEC,
          ptc_pkg::CFG_DATA_W'(ptc_pkg::SRATE_RESET));
    queue_cmd(ptc_pkg::OP_START, '0, ptc_pkg::TGT_W'(5 * ONE_SEC));
    queue_cmd(ptc_pkg::OP_TICK, 32'h0000_1000, '0);
    queue_cmd(ptc_pkg::OP_START, '0, ptc_pkg::TGT_W'(2 * ONE_SEC));
    queue_cmd(ptc_pkg::OP_TICK, 32'h0080_0000, '0);
    queue_cmd(ptc_pkg::OP_TICK, 32'h0080_0000, '0);
    drain();

    // The widest sample rate with the largest position gives the largest sample count.
    write_reg(ptc_pkg::CFG_SRATE, '1);
    write_reg(ptc_pkg::CFG_DURATION, '0);
    queue_cmd(ptc_pkg::OP_SEEK, '0, {1'b0, {ptc_pkg::POS_W{1'b1}}});
    drain();
    write_reg(ptc_pkg::CFG_SRATE, '0);
    write_reg(ptc_pkg::CFG_RATE, '0);
    queue_cmd(ptc_pkg::OP_START, '0, ptc_pkg::TGT_W'(ONE_SEC));
    queue_cmd(ptc_pkg::OP_TICK, 32'h0100_0000, '0);
    drain();

    setup(ptc_pkg::CFG_DATA_W'(ptc_pkg::RATE_RESET), 0, 0, 0, 8 * ONE_SEC,
          ptc_pkg::CFG_DATA_W'(ptc_pkg::SRATE_RESET));
    run_random(PHASE_ITEMS);
    quiet = 1'b1;
    setup(2 << ptc_pkg::RATE_FRAC, 1, ONE_SEC, 3 * ONE_SEC, 5 * ONE_SEC, 44100);
    run_random(PHASE_ITEMS);
    quiet = 1'b0;
    setup(1 << (ptc_pkg::RATE_FRAC - 1), 1, ONE_SEC / 2, 0, 4 * ONE_SEC, 96000);
    run_random(PHASE_ITEMS);
    setup(40'hAB_00FF_FFFF, 0, 0, 0, ptc_pkg::POS_MAX, 400000);
    run_random(PHASE_ITEMS);
    setup(1, 3, 0, 3, 0, 0);
    run_random(PHASE_ITEMS);
    setup(40'hFF_FFFF, 1, 2 * ONE_SEC, ONE_SEC, 0, ptc_pkg::CFG_DATA_W'(ptc_pkg::SRATE_RESET));
    run_random(PHASE_ITEMS);
    setup(ptc_pkg::CFG_DATA_W'(ptc_pkg::RATE_RESET), 1, ptc_pkg::POS_MAX - 5,
          ptc_pkg::POS_MAX, 0, ptc_pkg::CFG_DATA_W'(ptc_pkg::SRATE_RESET));
    run_random(PHASE_ITEMS);
    setup(1, 2, 0, 0, 1, 22050);
    run_random(PHASE_ITEMS);
    repeat (3) begin
      setup(ptc_pkg::CFG_DATA_W'($urandom_range(1, 24'hFF_FFFF)),
            ptc_pkg::CFG_DATA_W'($urandom_range(0, 1)),
            ptc_pkg::CFG_DATA_W'($urandom() >> $urandom_range(0, 6)),
            ptc_pkg::CFG_DATA_W'($urandom() >> $urandom_range(0, 6)),
            ptc_pkg::CFG_DATA_W'($urandom() >> $urandom_range(0, 6)),
            ptc_pkg::CFG_DATA_W'($urandom_range(0, 400000)));
      run_random(PHASE_ITEMS);
    end

    repeat (120) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_if.sv
rtl/core/ptc_mul.sv
rtl/core/ptc_rem.sv
rtl/core/playback_transport_clock_top.sv
bench/tb.sv
